[rtl/core/cau_pkg.sv]
// Shared operation and status codes for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

endpackage
`default_nettype wire

[rtl/core/complex_arith_unit.sv]
// Top level of the pipelined complex arithmetic unit.
`default_nettype none
// Complex add, subtract, multiply, divide and negate on signed fixed-point
// operands (Q16.16 by default). One beat is taken every cycle unless a held
// result stalls the pipeline; every operation passes through the bit-per-stage
// quotient pipeline of the divider, so results stay in order. Products and
// quotients truncate toward zero; results saturate with an overflow status;
// a zero divisor gives zeros with a divide-by-zero status. An output register
// holds a result that is not taken; the pipeline advances behind it until the
// next result reaches the divider output, then stalls.
module complex_arith_unit import cau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [2:0]                   req_type,
   input  wire logic signed [DATA_WIDTH-1:0] req_a_real,
   input  wire logic signed [DATA_WIDTH-1:0] req_a_imag,
   input  wire logic signed [DATA_WIDTH-1:0] req_b_real,
   input  wire logic signed [DATA_WIDTH-1:0] req_b_imag,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0]      rsp_res_real,
   output logic signed [DATA_WIDTH-1:0]      rsp_res_imag,
   output logic [1:0]                        rsp_status
);

   localparam int W  = DATA_WIDTH;
   localparam int MW = 2*DATA_WIDTH+1;
   localparam int PW = 2*DATA_WIDTH;
   localparam int QW = DATA_WIDTH+1;
   localparam logic [MW-1:0] LIM_POS = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [MW-1:0] LIM_NEG = LIM_POS + MW'(1);

   typedef struct packed {
      op_type        op;
      logic          dz;
      logic          neg_r;
      logic          neg_i;
      logic [MW-1:0] mag_r;
      logic [MW-1:0] mag_i;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   logic en;

   // stage 1: products and linear ops
   logic                 s1_valid_ff;
   op_type               s1_op_ff;
   logic signed [PW-1:0] s1_p_rr_ff, s1_p_ii_ff, s1_p_ri_ff, s1_p_ir_ff;
   logic signed [PW-1:0] s1_p_bb_ff, s1_p_cc_ff;
   logic signed [W:0]    s1_lin_r_ff, s1_lin_i_ff;
   logic signed [W:0]    s1_lin_r_in, s1_lin_i_in;
   op_type               req_op;

   assign req_op = op_type'(req_type);

   always_comb begin
      case (req_op)
         OP_ADD: begin
            s1_lin_r_in = {req_a_real[W-1], req_a_real} + {req_b_real[W-1], req_b_real};
            s1_lin_i_in = {req_a_imag[W-1], req_a_imag} + {req_b_imag[W-1], req_b_imag};
         end
         OP_SUB: begin
            s1_lin_r_in = {req_a_real[W-1], req_a_real} - {req_b_real[W-1], req_b_real};
            s1_lin_i_in = {req_a_imag[W-1], req_a_imag} - {req_b_imag[W-1], req_b_imag};
         end
         OP_NEG: begin
            s1_lin_r_in = -{req_a_real[W-1], req_a_real};
            s1_lin_i_in = -{req_a_imag[W-1], req_a_imag};
         end
         default: begin
            s1_lin_r_in = '0;
            s1_lin_i_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_op_ff    <= req_op;
         s1_p_rr_ff  <= PW'(req_a_real * req_b_real);
         s1_p_ii_ff  <= PW'(req_a_imag * req_b_imag);
         s1_p_ri_ff  <= PW'(req_a_real * req_b_imag);
         s1_p_ir_ff  <= PW'(req_a_imag * req_b_real);
         s1_p_bb_ff  <= PW'(req_b_real * req_b_real);
         s1_p_cc_ff  <= PW'(req_b_imag * req_b_imag);
         s1_lin_r_ff <= s1_lin_r_in;
         s1_lin_i_ff <= s1_lin_i_in;
      end
   end

   // stage 2: sums and divisor
   logic                 s2_valid_ff;
   op_type               s2_op_ff;
   logic signed [MW-1:0] s2_sum_r_ff, s2_sum_i_ff, s2_sum_r_in, s2_sum_i_in;
   logic [PW-1:0]        s2_den_ff;
   logic signed [MW-1:0] e_rr, e_ii, e_ri, e_ir;

   assign e_rr = MW'(s1_p_rr_ff);
   assign e_ii = MW'(s1_p_ii_ff);
   assign e_ri = MW'(s1_p_ri_ff);
   assign e_ir = MW'(s1_p_ir_ff);

   always_comb begin
      case (s1_op_ff)
         OP_ADD, OP_SUB, OP_NEG: begin
            s2_sum_r_in = MW'(s1_lin_r_ff);
            s2_sum_i_in = MW'(s1_lin_i_ff);
         end
         OP_MUL: begin
            s2_sum_r_in = e_rr - e_ii;
            s2_sum_i_in = e_ri + e_ir;
         end
         OP_DIV: begin
            s2_sum_r_in = e_rr + e_ii;
            s2_sum_i_in = e_ir - e_ri;
         end
         default: begin
            s2_sum_r_in = '0;
            s2_sum_i_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_op_ff    <= s1_op_ff;
         s2_sum_r_ff <= s2_sum_r_in;
         s2_sum_i_ff <= s2_sum_i_in;
         s2_den_ff   <= $unsigned(s1_p_bb_ff) + $unsigned(s1_p_cc_ff);
      end
   end

   // stage 3: sign and magnitude
   logic          s3_valid_ff;
   side_type      s3_side_ff, s3_side_in;
   logic [PW-1:0] s3_den_ff;
   logic [MW-1:0] abs_r, abs_i;

   always_comb begin
      abs_r = s2_sum_r_ff[MW-1] ? -$unsigned(s2_sum_r_ff) : $unsigned(s2_sum_r_ff);
      abs_i = s2_sum_i_ff[MW-1] ? -$unsigned(s2_sum_i_ff) : $unsigned(s2_sum_i_ff);
      s3_side_in.op    = s2_op_ff;
      s3_side_in.dz    = (s2_den_ff == '0);
      s3_side_in.neg_r = s2_sum_r_ff[MW-1];
      s3_side_in.neg_i = s2_sum_i_ff[MW-1];
      if (s2_op_ff == OP_MUL) begin
         s3_side_in.mag_r = abs_r >> FRAC_BITS;
         s3_side_in.mag_i = abs_i >> FRAC_BITS;
      end else begin
         s3_side_in.mag_r = abs_r;
         s3_side_in.mag_i = abs_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_side_ff <= s3_side_in;
         s3_den_ff  <= s2_den_ff;
      end
   end

   // quotient pipeline
   logic              dv_valid;
   logic [QW-1:0]     dv_q_r, dv_q_i;
   logic              dv_big_r, dv_big_i;
   logic [SIDE_W-1:0] dv_side_raw;
   side_type          dv_side;

   cau_divider #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .SIDE_W     (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_mag_r  (s3_side_ff.mag_r),
      .in_mag_i  (s3_side_ff.mag_i),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_q_r   (dv_q_r),
      .out_q_i   (dv_q_i),
      .out_big_r (dv_big_r),
      .out_big_i (dv_big_i),
      .out_side  (dv_side_raw)
   );

   assign dv_side = side_type'(dv_side_raw);

   // saturation; returns {overflow, value}
   function automatic logic [W:0] sat_part(input logic neg, input logic [MW-1:0] mag,
                                           input logic big);
      logic [W-1:0] val;
      logic         ovf;
      ovf = big || (neg ? (mag > LIM_NEG) : (mag > LIM_POS));
      if (ovf) begin
         val = neg ? LIM_NEG[W-1:0] : LIM_POS[W-1:0];
      end else begin
         val = neg ? -mag[W-1:0] : mag[W-1:0];
      end
      return {ovf, val};
   endfunction

   logic [W:0]    fin_r, fin_i;
   logic [MW-1:0] fm_r, fm_i;
   logic          fb_r, fb_i;
   logic [W-1:0]  out_r_in, out_i_in;
   logic [1:0]    out_st_in;

   always_comb begin
      if (dv_side.op == OP_DIV) begin
         fm_r = MW'(dv_q_r);
         fm_i = MW'(dv_q_i);
         fb_r = dv_big_r;
         fb_i = dv_big_i;
      end else begin
         fm_r = dv_side.mag_r;
         fm_i = dv_side.mag_i;
         fb_r = 1'b0;
         fb_i = 1'b0;
      end
      fin_r = sat_part(dv_side.neg_r, fm_r, fb_r);
      fin_i = sat_part(dv_side.neg_i, fm_i, fb_i);
      case (dv_side.op)
         OP_ADD, OP_SUB, OP_MUL, OP_NEG: begin
            out_r_in  = fin_r[W-1:0];
            out_i_in  = fin_i[W-1:0];
            out_st_in = (fin_r[W] || fin_i[W]) ? ST_OVF : ST_OK;
         end
         OP_DIV: begin
            if (dv_side.dz) begin
               out_r_in  = '0;
               out_i_in  = '0;
               out_st_in = ST_DZ;
            end else begin
               out_r_in  = fin_r[W-1:0];
               out_i_in  = fin_i[W-1:0];
               out_st_in = (fin_r[W] || fin_i[W]) ? ST_OVF : ST_OK;
            end
         end
         default: begin
            out_r_in  = '0;
            out_i_in  = '0;
            out_st_in = ST_OK;
         end
      endcase
   end

   // output register
   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_res_real_ff, rsp_res_imag_ff;
   logic [1:0]          rsp_status_ff;

   assign en = !dv_valid || !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= dv_valid;
      end
      if ((!rsp_valid_ff || rsp_ready) && dv_valid) begin
         rsp_res_real_ff <= out_r_in;
         rsp_res_imag_ff <= out_i_in;
         rsp_status_ff   <= out_st_in;
      end
   end

   assign req_ready    = en;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_real = rsp_res_real_ff;
   assign rsp_res_imag = rsp_res_imag_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("pipeline stalled without a blocked result");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DZ) |-> (rsp_res_real == '0 && rsp_res_imag == '0))
      else $error("divide by zero result not cleared");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OVF) |->
         (rsp_res_real == LIM_POS[W-1:0] || rsp_res_real == LIM_NEG[W-1:0] ||
          rsp_res_imag == LIM_POS[W-1:0] || rsp_res_imag == LIM_NEG[W-1:0]))
      else $error("overflow status without a saturated part");

   a_no_bad_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_OVF || rsp_status == ST_DZ))
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire

[rtl/core/cau_divider.sv]
// Pipelined restoring divider: two quotients over a shared divisor, one bit per stage.
`default_nettype none
module cau_divider import cau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int SIDE_W     = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [2*DATA_WIDTH:0]     in_mag_r,
   input  wire logic [2*DATA_WIDTH:0]     in_mag_i,
   input  wire logic [2*DATA_WIDTH-1:0]   in_den,
   input  wire logic [SIDE_W-1:0]         in_side,
   output logic                           out_valid,
   output logic [DATA_WIDTH:0]            out_q_r,
   output logic [DATA_WIDTH:0]            out_q_i,
   output logic                           out_big_r,
   output logic                           out_big_i,
   output logic [SIDE_W-1:0]              out_side
);

   localparam int MW = 2*DATA_WIDTH+1;
   localparam int PW = 2*DATA_WIDTH;
   localparam int QW = DATA_WIDTH+1;

   logic             valid_ff [0:QW];
   logic [PW-1:0]    rem_r_ff [0:QW];
   logic [PW-1:0]    rem_i_ff [0:QW];
   logic [QW-1:0]    low_r_ff [0:QW];
   logic [QW-1:0]    low_i_ff [0:QW];
   logic [QW-1:0]    q_r_ff   [0:QW];
   logic [QW-1:0]    q_i_ff   [0:QW];
   logic             big_r_ff [0:QW];
   logic             big_i_ff [0:QW];
   logic [PW-1:0]    den_ff   [0:QW];
   logic [SIDE_W-1:0] side_ff [0:QW];

   logic [MW-1:0]    top_r_in, top_i_in;
   logic [MW+QW-1:0] shl_r_in, shl_i_in;

   // leading part of the scaled dividend; quotient must fit QW bits
   always_comb begin
      top_r_in = in_mag_r >> (QW-FRAC_BITS);
      top_i_in = in_mag_i >> (QW-FRAC_BITS);
      shl_r_in = {{QW{1'b0}}, in_mag_r} << FRAC_BITS;
      shl_i_in = {{QW{1'b0}}, in_mag_i} << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_r_ff[0] <= top_r_in[PW-1:0];
         rem_i_ff[0] <= top_i_in[PW-1:0];
         low_r_ff[0] <= shl_r_in[QW-1:0];
         low_i_ff[0] <= shl_i_in[QW-1:0];
         q_r_ff[0]   <= '0;
         q_i_ff[0]   <= '0;
         big_r_ff[0] <= top_r_in >= {1'b0, in_den};
         big_i_ff[0] <= top_i_in >= {1'b0, in_den};
         den_ff[0]   <= in_den;
         side_ff[0]  <= in_side;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [MW-1:0] t_r, t_i;
      logic          ge_r, ge_i;
      logic [MW-1:0] d_r, d_i;

      always_comb begin
         t_r  = {rem_r_ff[k-1], low_r_ff[k-1][QW-1]};
         t_i  = {rem_i_ff[k-1], low_i_ff[k-1][QW-1]};
         ge_r = t_r >= {1'b0, den_ff[k-1]};
         ge_i = t_i >= {1'b0, den_ff[k-1]};
         d_r  = ge_r ? t_r - {1'b0, den_ff[k-1]} : t_r;
         d_i  = ge_i ? t_i - {1'b0, den_ff[k-1]} : t_i;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            rem_r_ff[k] <= d_r[PW-1:0];
            rem_i_ff[k] <= d_i[PW-1:0];
            low_r_ff[k] <= low_r_ff[k-1] << 1;
            low_i_ff[k] <= low_i_ff[k-1] << 1;
            q_r_ff[k]   <= {q_r_ff[k-1][QW-2:0], ge_r};
            q_i_ff[k]   <= {q_i_ff[k-1][QW-2:0], ge_i};
            big_r_ff[k] <= big_r_ff[k-1];
            big_i_ff[k] <= big_i_ff[k-1];
            den_ff[k]   <= den_ff[k-1];
            side_ff[k]  <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_q_r   = q_r_ff[QW];
   assign out_q_i   = q_i_ff[QW];
   assign out_big_r = big_r_ff[QW];
   assign out_big_i = big_i_ff[QW];
   assign out_side  = side_ff[QW];

endmodule
`default_nettype wire

[test/tb_complex_arith_unit.sv]
// Testbench for complex_arith_unit: directed table and random beats, checked by table or predictor.
`timescale 1ns / 100ps
module tb_complex_arith_unit;
   import cau_pkg::*;

   localparam int W = 32;
   localparam int FB = 16;
   localparam int RANDOM_BEATS = 1030;
   localparam int CALM_BEATS = 150;
   localparam int LATENCY = W + 6;
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam logic signed [W-1:0] MAXV = 32'sh7fffffff;
   localparam logic signed [W-1:0] MINV = 32'sh80000000;
   localparam logic signed [W-1:0] ONE = 32'sh00010000;

   typedef logic signed [129:0] wide_type;

   typedef struct packed {
      logic signed [W-1:0] re;
      logic signed [W-1:0] im;
      status_type          st;
   } cplx_rsp_type;

   typedef struct {
      logic [2:0]          op;
      logic signed [W-1:0] ar, ai, br, bi;
      bit                  typed;
      cplx_rsp_type        want;
   } vec_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_type = '0;
   logic signed [W-1:0] req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [W-1:0] rsp_res_real, rsp_res_imag;
   logic [1:0] rsp_status;

   bit           typed_now = 0;
   cplx_rsp_type typed_want;
   cplx_rsp_type pending_rsp[$];
   int           beats_in = 0;
   int           beats_out = 0;
   int           errors = 0;
   bit           calm = 0;
   int           op_seen[8];

   complex_arith_unit uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("complex_arith_unit: mismatch");
      $finish;
   end

   function automatic logic signed [W-1:0] clamp(input wide_type v, inout bit ovf);
      if (v > wide_type'(MAXV)) begin
         ovf = 1;
         return MAXV;
      end
      if (v < wide_type'(MINV)) begin
         ovf = 1;
         return MINV;
      end
      return v[W-1:0];
   endfunction

   function automatic wide_type shift_toward_zero(input wide_type v);
      wide_type mag;
      mag = (v < 0) ? -v : v;
      mag = mag >>> FB;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic wide_type quotient(input wide_type n, input wide_type d);
      wide_type mag;
      mag = (n < 0) ? -n : n;
      mag = (mag <<< FB) / d;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic cplx_rsp_type complex_result(input logic [2:0] op,
         input logic signed [W-1:0] ar, ai, br, bi);
      cplx_rsp_type r;
      wide_type xr, xi, den;
      bit ovf;
      ovf = 0;
      r = '{re: '0, im: '0, st: ST_OK};
      case (op)
         OP_ADD: begin
            xr = wide_type'(ar) + wide_type'(br);
            xi = wide_type'(ai) + wide_type'(bi);
         end
         OP_SUB: begin
            xr = wide_type'(ar) - wide_type'(br);
            xi = wide_type'(ai) - wide_type'(bi);
         end
         OP_MUL: begin
            xr = shift_toward_zero(wide_type'(ar) * wide_type'(br)
                                   - wide_type'(ai) * wide_type'(bi));
            xi = shift_toward_zero(wide_type'(ar) * wide_type'(bi)
                                   + wide_type'(br) * wide_type'(ai));
         end
         OP_DIV: begin
            den = wide_type'(br) * wide_type'(br) + wide_type'(bi) * wide_type'(bi);
            if (den == 0) begin
               r.st = ST_DZ;
               return r;
            end
            xr = quotient(wide_type'(ar) * wide_type'(br) + wide_type'(ai) * wide_type'(bi),
                          den);
            xi = quotient(wide_type'(br) * wide_type'(ai) - wide_type'(ar) * wide_type'(bi),
                          den);
         end
         OP_NEG: begin
            xr = -wide_type'(ar);
            xi = -wide_type'(ai);
         end
         default: return r;
      endcase
      r.re = clamp(xr, ovf);
      r.im = clamp(xi, ovf);
      r.st = ovf ? ST_OVF : ST_OK;
      return r;
   endfunction

   function automatic logic signed [W-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3: return $urandom_range(0, 1) ? ONE : -ONE;
         4, 5: return W'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pending_rsp.push_back(typed_now ? typed_want :
            complex_result(req_type, req_a_real, req_a_imag, req_b_real, req_b_imag));
         op_seen[req_type]++;
         beats_in++;
      end
   end

   always @(posedge clock) begin
      cplx_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing pending");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_res_real !== want.re) begin
               $error("res_real: expected %0d, got %0d", want.re, rsp_res_real);
               errors++;
            end
            if (rsp_res_imag !== want.im) begin
               $error("res_imag: expected %0d, got %0d", want.im, rsp_res_imag);
               errors++;
            end
            if (rsp_status !== want.st) begin
               $error("status: expected %0d, got %0d", want.st, rsp_status);
               errors++;
            end
         end
      end
   end

   // response-side stalls
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1;
         n = $urandom_range(1, 20);
         repeat (n) @(negedge clock);
      end
   end

   task automatic send_beat(input vec_type v);
      int start, gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_type <= v.op;
      req_a_real <= v.ar;
      req_a_imag <= v.ai;
      req_b_real <= v.br;
      req_b_imag <= v.bi;
      typed_now <= v.typed;
      typed_want <= v.want;
      start = beats_in;
      do @(negedge clock); while (beats_in == start);
   endtask

   vec_type directed[$];

   initial begin
      vec_type v;
      logic [2:0] op;
      directed = '{
         '{OP_ADD, 0, 0, 0, 0, 1, '{0, 0, ST_OK}},
         '{OP_ADD, MAXV, MAXV, ONE, ONE, 1, '{MAXV, MAXV, ST_OVF}},
         '{OP_ADD, MINV, MINV, -1, -1, 1, '{MINV, MINV, ST_OVF}},
         '{OP_SUB, MINV, MAXV, 1, -1, 1, '{MINV, MAXV, ST_OVF}},
         '{OP_SUB, MAXV, MINV, MAXV, MINV, 1, '{0, 0, ST_OK}},
         '{OP_MUL, ONE, 0, ONE, 0, 1, '{ONE, 0, ST_OK}},
         '{OP_MUL, MINV, MINV, MINV, MINV, 0, '{0, 0, ST_OK}},
         '{OP_MUL, MAXV, MINV, MAXV, MAXV, 0, '{0, 0, ST_OK}},
         '{OP_MUL, -3, 5, 7, -1, 0, '{0, 0, ST_OK}},
         '{OP_MUL, 32'sh18000, -32'sh28000, -32'sh8000, 32'sh30000, 0, '{0, 0, ST_OK}},
         '{OP_DIV, 12345, -678, 0, 0, 1, '{0, 0, ST_DZ}},
         '{OP_DIV, MAXV, MINV, 0, 0, 1, '{0, 0, ST_DZ}},
         '{OP_DIV, ONE, 0, ONE, 0, 1, '{ONE, 0, ST_OK}},
         '{OP_DIV, MAXV, MAXV, 1, 0, 1, '{MAXV, MAXV, ST_OVF}},
         '{OP_DIV, MINV, MINV, MINV, MINV, 0, '{0, 0, ST_OK}},
         '{OP_DIV, -ONE, 3, 32'sh30000, -7, 0, '{0, 0, ST_OK}},
         '{OP_DIV, 1, -1, MAXV, MINV, 0, '{0, 0, ST_OK}},
         '{OP_NEG, MINV, MINV, 0, 0, 1, '{MAXV, MAXV, ST_OVF}},
         '{OP_NEG, MAXV, 0, 5, 5, 1, '{-MAXV, 0, ST_OK}},
         '{OP_NEG, ONE, -ONE, MINV, MAXV, 1, '{-ONE, ONE, ST_OK}},
         '{OP_SPARE5, MAXV, MINV, 1, 1, 1, '{0, 0, ST_OK}},
         '{OP_SPARE6, -1, -1, -1, -1, 1, '{0, 0, ST_OK}},
         '{OP_SPARE7, 1, 2, 3, 4, 1, '{0, 0, ST_OK}}
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[i]) send_beat(directed[i]);
      for (int k = 0; k < RANDOM_BEATS; k++) begin
         calm = (k >= RANDOM_BEATS - CALM_BEATS);
         op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         v = '{op, pick_operand(), pick_operand(), pick_operand(), pick_operand(), 0,
               '{0, 0, ST_OK}};
         if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
            v.br = '0;
            v.bi = '0;
         end
         send_beat(v);
      end
      req_valid <= 0;
      typed_now <= 0;
      wait (pending_rsp.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d request beats, %0d result beats; add %0d sub %0d mul %0d div %0d neg %0d",
               beats_in, beats_out, op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
               op_seen[OP_DIV], op_seen[OP_NEG]);
      $display("unused codes %0d, extreme and zero operands mixed with random ones",
               op_seen[OP_SPARE5] + op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("complex_arith_unit: match");
      end else begin
         $display("complex_arith_unit: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/cau_pkg.sv
rtl/core/cau_divider.sv
rtl/core/complex_arith_unit.sv
test/tb_complex_arith_unit.sv
